FILE: sv/plane_stress_principals_top_assert.svh
// Assertion macros for the plane-stress principal stress block.
// Used by plane_stress_principals_top; expects clk and rst_n in scope.
`ifndef PLANE_STRESS_PRINCIPALS_TOP_ASSERT_SVH
`define PLANE_STRESS_PRINCIPALS_TOP_ASSERT_SVH

// Implication checked on every edge outside reset.
`define PSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every edge outside reset.
`define PSP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

FILE: sv/psp_pkg.sv
// Shared width and latency helpers for the plane-stress principal stress block.
// No dependencies.
package psp_pkg;

    // Width of the lower part when a DATA_WIDTH operand is split for squaring.
    function automatic int half_width(input int w);
        return (w + 1) >> 1;
    endfunction

    // Width of the square-root partial remainder.
    function automatic int rem_width(input int w);
        return w + 2;
    endfunction

    // Cycles from the transfer edge of an item to the edge that takes its result.
    function automatic int total_latency(input int w);
        return w + 5;
    endfunction

endpackage

FILE: sv/psp_square.sv
// Front end: centre, half difference and shear magnitudes, split squaring,
// and the exact radicand sum. Four register stages. Depends on psp_pkg.
module psp_square
    import psp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [DATA_WIDTH-1:0]     xx,
    input  logic [DATA_WIDTH-1:0]     yy,
    input  logic [DATA_WIDTH-1:0]     xy,
    output logic                      out_valid,
    output logic [DATA_WIDTH-1:0]     out_centre,
    output logic [2*DATA_WIDTH-1:0]   out_rad
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int LW = half_width(DATA_WIDTH);   // low part width
    localparam int UW = DATA_WIDTH - LW;          // high part width

    // stage 1
    logic [W:0]         sum_w;
    logic [W:0]         diff_w;
    logic [W-1:0]       half_diff;
    logic [W-1:0]       d_mag_next;
    logic [W-1:0]       s_mag_next;
    logic               v1_reg;
    logic [W-1:0]       c1_reg;
    logic [W-1:0]       d_mag_reg;
    logic [W-1:0]       s_mag_reg;

    // stage 2
    logic [2*UW-1:0]    d_hh_reg;
    logic [W-1:0]       d_hl_reg;
    logic [2*LW-1:0]    d_ll_reg;
    logic [2*UW-1:0]    s_hh_reg;
    logic [W-1:0]       s_hl_reg;
    logic [2*LW-1:0]    s_ll_reg;
    logic               v2_reg;
    logic [W-1:0]       c2_reg;

    // stage 3
    logic [PW-1:0]      d_sq_next;
    logic [PW-1:0]      s_sq_next;
    logic [PW-1:0]      d_sq_reg;
    logic [PW-1:0]      s_sq_reg;
    logic               v3_reg;
    logic [W-1:0]       c3_reg;

    // stage 4
    logic               v4_reg;
    logic [W-1:0]       c4_reg;
    logic [PW-1:0]      rad_reg;

    always_comb
    begin
        sum_w      = {xx[W-1], xx} + {yy[W-1], yy};
        diff_w     = {xx[W-1], xx} - {yy[W-1], yy};
        // floor halving is an arithmetic shift of the widened value
        half_diff  = diff_w[W:1];
        d_mag_next = half_diff[W-1] ? (~half_diff + 1'b1) : half_diff;
        s_mag_next = xy[W-1] ? (~xy + 1'b1) : xy;
    end

    always_comb
    begin
        d_sq_next = (PW'(d_hh_reg) << (2 * LW)) + (PW'(d_hl_reg) << (LW + 1))
                  + PW'(d_ll_reg);
        s_sq_next = (PW'(s_hh_reg) << (2 * LW)) + (PW'(s_hl_reg) << (LW + 1))
                  + PW'(s_ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg    <= sum_w[W:1];
        d_mag_reg <= d_mag_next;
        s_mag_reg <= s_mag_next;

        d_hh_reg  <= (2*UW)'(d_mag_reg[W-1:LW]) * (2*UW)'(d_mag_reg[W-1:LW]);
        d_hl_reg  <= W'(d_mag_reg[W-1:LW]) * W'(d_mag_reg[LW-1:0]);
        d_ll_reg  <= (2*LW)'(d_mag_reg[LW-1:0]) * (2*LW)'(d_mag_reg[LW-1:0]);
        s_hh_reg  <= (2*UW)'(s_mag_reg[W-1:LW]) * (2*UW)'(s_mag_reg[W-1:LW]);
        s_hl_reg  <= W'(s_mag_reg[W-1:LW]) * W'(s_mag_reg[LW-1:0]);
        s_ll_reg  <= (2*LW)'(s_mag_reg[LW-1:0]) * (2*LW)'(s_mag_reg[LW-1:0]);
        c2_reg    <= c1_reg;

        d_sq_reg  <= d_sq_next;
        s_sq_reg  <= s_sq_next;
        c3_reg    <= c2_reg;

        rad_reg   <= d_sq_reg + s_sq_reg;
        c4_reg    <= c3_reg;
    end

    assign out_valid  = v4_reg;
    assign out_centre = c4_reg;
    assign out_rad    = rad_reg;

endmodule

FILE: sv/psp_sqrt_stage.sv
// One restoring square-root step: brings down two radicand bits, decides one
// root bit. Carries the centre alongside. Depends on psp_pkg.
module psp_sqrt_stage
    import psp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [rem_width(DATA_WIDTH)-1:0]      in_rem,
    input  logic [DATA_WIDTH-1:0]                 in_root,
    input  logic [2*DATA_WIDTH-1:0]               in_rad,
    input  logic [DATA_WIDTH-1:0]                 in_centre,
    output logic                                  out_valid,
    output logic [rem_width(DATA_WIDTH)-1:0]      out_rem,
    output logic [DATA_WIDTH-1:0]                 out_root,
    output logic [2*DATA_WIDTH-1:0]               out_rad,
    output logic [DATA_WIDTH-1:0]                 out_centre
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = rem_width(DATA_WIDTH);
    localparam int AW = RW + 2;

    logic [AW-1:0]      acc;
    logic [AW-1:0]      trial;
    logic [AW-1:0]      diff;
    logic [RW-1:0]      rem_next;
    logic [W-1:0]       root_next;
    logic               valid_reg;
    logic [RW-1:0]      rem_reg;
    logic [W-1:0]       root_reg;
    logic [2*W-1:0]     rad_reg;
    logic [W-1:0]       centre_reg;

    always_comb
    begin
        acc   = {in_rem, in_rad[2*W-1 -: 2]};
        trial = AW'({in_root, 2'b01});
        diff  = acc - trial;
        if (acc >= trial)
        begin
            rem_next  = diff[RW-1:0];
            root_next = {in_root[W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = acc[RW-1:0];
            root_next = {in_root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        rad_reg    <= {in_rad[2*W-3:0], 2'b00};
        centre_reg <= in_centre;
    end

    assign out_valid  = valid_reg;
    assign out_rem    = rem_reg;
    assign out_root   = root_reg;
    assign out_rad    = rad_reg;
    assign out_centre = centre_reg;

endmodule

FILE: sv/plane_stress_principals_top.sv
// Principal stresses of a plane-stress tensor. Throughput: one item per cycle;
// busy is always low and done cannot be held off. Four front stages (halving,
// split squares, sum), one stage per root bit, one output stage. Reset (async,
// active low) clears only the valid pipeline.
`include "plane_stress_principals_top_assert.svh"

module plane_stress_principals_top
    import psp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [DATA_WIDTH-1:0]     stress_xx,
    input  logic [DATA_WIDTH-1:0]     stress_yy,
    input  logic [DATA_WIDTH-1:0]     shear_in_plane,
    output logic                      done,
    output logic [DATA_WIDTH+1:0]     principal_major,
    output logic [DATA_WIDTH+1:0]     principal_minor,
    output logic [DATA_WIDTH-1:0]     max_shear
);

    localparam int W       = DATA_WIDTH;
    localparam int RW      = rem_width(DATA_WIDTH);
    localparam int LATENCY = total_latency(DATA_WIDTH);

    logic               sv_valid [0:W];
    logic [RW-1:0]      sv_rem   [0:W];
    logic [W-1:0]       sv_root  [0:W];
    logic [2*W-1:0]     sv_rad   [0:W];
    logic [W-1:0]       sv_centre[0:W];

    logic [W+1:0]       centre_ext;
    logic [W+1:0]       root_ext;
    logic [W+1:0]       shear_ext;
    logic               in_xfer;
    logic               done_reg;
    logic [W+1:0]       major_reg;
    logic [W+1:0]       minor_reg;
    logic [W-1:0]       shear_reg;

    assign busy = 1'b0;

    psp_square #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_square (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .xx         (stress_xx),
        .yy         (stress_yy),
        .xy         (shear_in_plane),
        .out_valid  (sv_valid[0]),
        .out_centre (sv_centre[0]),
        .out_rad    (sv_rad[0])
    );

    assign sv_rem[0]  = '0;
    assign sv_root[0] = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_root
        psp_sqrt_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (sv_valid[k]),
            .in_rem     (sv_rem[k]),
            .in_root    (sv_root[k]),
            .in_rad     (sv_rad[k]),
            .in_centre  (sv_centre[k]),
            .out_valid  (sv_valid[k+1]),
            .out_rem    (sv_rem[k+1]),
            .out_root   (sv_root[k+1]),
            .out_rad    (sv_rad[k+1]),
            .out_centre (sv_centre[k+1])
        );
    end

    always_comb
    begin
        centre_ext = {{2{sv_centre[W][W-1]}}, sv_centre[W]};
        root_ext   = {2'b00, sv_root[W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sv_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= centre_ext + root_ext;
        minor_reg <= centre_ext - root_ext;
        shear_reg <= sv_root[W];
    end

    assign done            = done_reg;
    assign principal_major = major_reg;
    assign principal_minor = minor_reg;
    assign max_shear       = shear_reg;

    assign shear_ext = {2'b00, max_shear};
    assign in_xfer   = start && !busy && rst_n;

    `PSP_ASSERT_SAME(a_done_has_start, done, $past(in_xfer, LATENCY), "done without a start transfer")
    `PSP_ASSERT_SAME(a_start_has_done, $past(in_xfer, LATENCY) === 1'b1, done, "no done for a transfer")
    `PSP_ASSERT_SAME(a_span_is_diameter, done, (principal_major - principal_minor) == (shear_ext << 1), "major minus minor is not twice the shear")
    `PSP_ASSERT_SAME(a_major_not_below, done, $signed(principal_major) >= $signed(principal_minor), "major principal below minor")

endmodule
